// File: rtl/tpi_pkg.sv
package tpi_pkg;

  // Field widths
  localparam int COORD_W = 21;
  localparam int YOUT_W  = 20;
  localparam int ANG_W   = 12;
  localparam int AOUT_W  = 13;
  localparam int W_W     = 11;
  localparam int IDX_W   = 8;
  localparam int KIND_W  = 3;
  localparam int CNT_W   = 9;
  localparam int OP_W    = 22;
  localparam int ACC_W   = 32;

  localparam logic [W_W-1:0]   W_FULL    = 11'h400;
  localparam logic [W_W-1:0]   W_HALF    = 11'h200;
  localparam logic [CNT_W-1:0] CNT_RESET = 9'd2;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE  = 3'd0,
    KIND_POS    = 3'd1,
    KIND_ANG    = 3'd2,
    KIND_REV    = 3'd3,
    KIND_SMOOTH = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ADDR_IDX,
    ADDR_BACK,
    ADDR_FWD
  } addr_sel_t;

  typedef enum logic [2:0] {
    MAC_X,
    MAC_Y,
    MAC_Z,
    MAC_ANG,
    MAC_H01,
    MAC_H02,
    MAC_H3A
  } mac_src_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_FLAG,
    RES_POS,
    RES_ANG,
    RES_REV
  } res_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_A1,
    ST_S1,
    ST_S2,
    ST_S3,
    ST_S4,
    ST_S5,
    ST_S6,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [ANG_W-1:0]          ang;
  } point_t;

  typedef struct packed {
    logic      latch;
    logic      rd_en;
    addr_sel_t addr_sel;
    mac_src_t  mac_src;
    logic      half_w;
    logic      save_x;
    logic      save_y;
    logic      hsave;
    logic [1:0] hsel;
    logic      hold;
    logic      load_out;
    res_sel_t  res_sel;
  } cmd_t;

  typedef struct packed {
    logic in_bad;
  } sts_t;

endpackage

// File: rtl/tpi_ifs.sv
interface tpi_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [tpi_pkg::KIND_W-1:0]           kind;
  logic [tpi_pkg::IDX_W-1:0]            point_index;
  logic [tpi_pkg::W_W-1:0]              weight;
  logic signed [tpi_pkg::COORD_W-1:0]   new_x;
  logic signed [tpi_pkg::COORD_W-1:0]   new_y;
  logic signed [tpi_pkg::COORD_W-1:0]   new_z;
  logic [tpi_pkg::ANG_W-1:0]            new_angle;

  modport source (output valid, kind, point_index, weight, new_x, new_y, new_z, new_angle,
                  input ready);
  modport sink (input valid, kind, point_index, weight, new_x, new_y, new_z, new_angle,
                output ready);
endinterface

interface tpi_res_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [tpi_pkg::COORD_W-1:0]   pos_x;
  logic signed [tpi_pkg::YOUT_W-1:0]    pos_y;
  logic signed [tpi_pkg::COORD_W-1:0]   pos_z;
  logic signed [tpi_pkg::AOUT_W-1:0]    angle_out;
  logic                                 bad_index;

  modport source (output valid, pos_x, pos_y, pos_z, angle_out, bad_index, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, angle_out, bad_index, output ready);
endinterface

interface tpi_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tpi_pkg::CNT_W-1:0]   point_count;

  modport source (output valid, point_count, input ready);
  modport sink (input valid, point_count, output ready);
endinterface

// File: rtl/tpi_ctrl.sv
module tpi_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [tpi_pkg::KIND_W-1:0] in_kind,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  tpi_pkg::sts_t              sts,
  output tpi_pkg::cmd_t              cmd
);

  tpi_pkg::state_t   state, state_next;
  tpi_pkg::kind_t    kind_q, kind_q_next;
  tpi_pkg::res_sel_t res_q, res_q_next;
  logic              out_valid_next;

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tpi_pkg::ST_IDLE;
      kind_q    <= tpi_pkg::KIND_WRITE;
      res_q     <= tpi_pkg::RES_NONE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      kind_q    <= kind_q_next;
      res_q     <= res_q_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_next  = state;
    kind_q_next = kind_q;
    res_q_next  = res_q;
    cmd         = '0;
    in_ready    = 1'b0;
    case (state)
      tpi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch   = 1'b1;
          kind_q_next = tpi_pkg::kind_t'(in_kind);
          case (tpi_pkg::kind_t'(in_kind))
            tpi_pkg::KIND_WRITE: begin
              res_q_next = tpi_pkg::RES_FLAG;
              state_next = tpi_pkg::ST_DONE;
            end
            tpi_pkg::KIND_POS, tpi_pkg::KIND_ANG, tpi_pkg::KIND_REV,
            tpi_pkg::KIND_SMOOTH: begin
              if (sts.in_bad) begin
                res_q_next = tpi_pkg::RES_FLAG;
                state_next = tpi_pkg::ST_DONE;
              end else begin
                state_next = tpi_pkg::ST_RD;
                if (tpi_pkg::kind_t'(in_kind) == tpi_pkg::KIND_POS) begin
                  res_q_next = tpi_pkg::RES_POS;
                end else if (tpi_pkg::kind_t'(in_kind) == tpi_pkg::KIND_REV) begin
                  res_q_next = tpi_pkg::RES_REV;
                end else begin
                  res_q_next = tpi_pkg::RES_ANG;
                end
              end
            end
            default: begin
              res_q_next = tpi_pkg::RES_NONE;
              state_next = tpi_pkg::ST_DONE;
            end
          endcase
        end
      end
      tpi_pkg::ST_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = tpi_pkg::ADDR_IDX;
        case (kind_q)
          tpi_pkg::KIND_POS:    state_next = tpi_pkg::ST_P1;
          tpi_pkg::KIND_SMOOTH: state_next = tpi_pkg::ST_S1;
          default:              state_next = tpi_pkg::ST_A1;
        endcase
      end
      // position: x, y, z through the shared multiply-add
      tpi_pkg::ST_P1: begin
        cmd.mac_src = tpi_pkg::MAC_X;
        state_next  = tpi_pkg::ST_P2;
      end
      tpi_pkg::ST_P2: begin
        cmd.mac_src = tpi_pkg::MAC_Y;
        cmd.save_x  = 1'b1;
        state_next  = tpi_pkg::ST_P3;
      end
      tpi_pkg::ST_P3: begin
        cmd.mac_src = tpi_pkg::MAC_Z;
        cmd.save_y  = 1'b1;
        state_next  = tpi_pkg::ST_DONE;
      end
      tpi_pkg::ST_A1: begin
        cmd.mac_src = tpi_pkg::MAC_ANG;
        state_next  = tpi_pkg::ST_DONE;
      end
      // smoothed: three segment headings, then three half blends
      tpi_pkg::ST_S1: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = tpi_pkg::ADDR_BACK;
        cmd.mac_src  = tpi_pkg::MAC_ANG;
        state_next   = tpi_pkg::ST_S2;
      end
      tpi_pkg::ST_S2: begin
        cmd.rd_en    = 1'b1;
        cmd.addr_sel = tpi_pkg::ADDR_FWD;
        cmd.mac_src  = tpi_pkg::MAC_ANG;
        cmd.hsave    = 1'b1;
        cmd.hsel     = 2'd0;
        state_next   = tpi_pkg::ST_S3;
      end
      tpi_pkg::ST_S3: begin
        cmd.mac_src = tpi_pkg::MAC_ANG;
        cmd.hsave   = 1'b1;
        cmd.hsel    = 2'd1;
        state_next  = tpi_pkg::ST_S4;
      end
      tpi_pkg::ST_S4: begin
        cmd.mac_src = tpi_pkg::MAC_H01;
        cmd.half_w  = 1'b1;
        cmd.hsave   = 1'b1;
        cmd.hsel    = 2'd2;
        state_next  = tpi_pkg::ST_S5;
      end
      tpi_pkg::ST_S5: begin
        cmd.mac_src = tpi_pkg::MAC_H02;
        cmd.half_w  = 1'b1;
        cmd.hsave   = 1'b1;
        cmd.hsel    = 2'd3;
        state_next  = tpi_pkg::ST_S6;
      end
      tpi_pkg::ST_S6: begin
        cmd.mac_src = tpi_pkg::MAC_H3A;
        cmd.half_w  = 1'b1;
        state_next  = tpi_pkg::ST_DONE;
      end
      tpi_pkg::ST_DONE: begin
        // keep the final sum while the output is busy
        cmd.hold = 1'b1;
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          cmd.res_sel  = res_q;
          state_next   = tpi_pkg::ST_IDLE;
        end
      end
      default: state_next = tpi_pkg::ST_IDLE;
    endcase
  end

  // Output register occupancy
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

endmodule

// File: rtl/tpi_dp.sv
module tpi_dp #(
  parameter int MAX_POINTS = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tpi_pkg::CNT_W-1:0]           cfg_data,
  input  logic [tpi_pkg::KIND_W-1:0]          in_kind,
  input  logic [tpi_pkg::IDX_W-1:0]           in_point_index,
  input  logic [tpi_pkg::W_W-1:0]             in_weight,
  input  logic signed [tpi_pkg::COORD_W-1:0]  in_new_x,
  input  logic signed [tpi_pkg::COORD_W-1:0]  in_new_y,
  input  logic signed [tpi_pkg::COORD_W-1:0]  in_new_z,
  input  logic [tpi_pkg::ANG_W-1:0]           in_new_angle,
  input  tpi_pkg::cmd_t                       cmd,
  output tpi_pkg::sts_t                       sts,
  output logic signed [tpi_pkg::COORD_W-1:0]  pos_x,
  output logic signed [tpi_pkg::YOUT_W-1:0]   pos_y,
  output logic signed [tpi_pkg::COORD_W-1:0]  pos_z,
  output logic signed [tpi_pkg::AOUT_W-1:0]   angle_out,
  output logic                                bad_index
);

  localparam int CW = ($clog2(MAX_POINTS + 1) > tpi_pkg::CNT_W) ?
                      $clog2(MAX_POINTS + 1) : tpi_pkg::CNT_W;
  localparam int IW = CW + 1;
  localparam int AW = $clog2(MAX_POINTS);

  // Shorter-way unwrap of two headings into 13-bit operands
  function automatic logic [2*(tpi_pkg::ANG_W+1)-1:0] wrap_pair(
    input logic [tpi_pkg::ANG_W-1:0] a,
    input logic [tpi_pkg::ANG_W-1:0] b
  );
    logic [tpi_pkg::ANG_W:0] lo;
    logic [tpi_pkg::ANG_W:0] hi;
    lo = {1'b0, a};
    hi = {1'b0, b};
    if (b < a) begin
      if ((a - b) >= 12'h801) hi = hi + 13'h1000;
    end else if ((b - a) >= 12'h801) begin
      lo = lo + 13'h1000;
    end
    return {lo, hi};
  endfunction

  logic [tpi_pkg::CNT_W-1:0]          point_count;
  logic [CW-1:0]                      pc_w, cnt_live, idx_live;
  logic [CW-1:0]                      cnt, idx;
  logic [tpi_pkg::W_W-1:0]            w;
  logic                               bad_q;
  logic                               wr_en;
  tpi_pkg::point_t                    mem [MAX_POINTS];
  tpi_pkg::point_t                    rd_a, rd_b;
  logic [IW-1:0]                      idx_e, cnt_e, back, fwd_raw, fwd, base, succ_raw, succ;
  logic [AW-1:0]                      addr_a, addr_b;
  logic [tpi_pkg::ANG_W-1:0]          h [4];
  logic [tpi_pkg::ANG_W-1:0]          ang_a, ang_b, acc_h;
  logic [2*(tpi_pkg::ANG_W+1)-1:0]    pair;
  logic signed [tpi_pkg::OP_W-1:0]    op_a, op_b;
  logic [tpi_pkg::W_W-1:0]            wv, inv;
  logic signed [tpi_pkg::ACC_W-1:0]   acc, prod_a, prod_b, acc_r10, acc_r11;
  logic signed [tpi_pkg::COORD_W-1:0] res_x;
  logic signed [tpi_pkg::YOUT_W-1:0]  res_y;

  // Point count register
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= tpi_pkg::CNT_RESET;
    end else if (cfg_we) begin
      point_count <= cfg_data;
    end
  end

  // Effective count and index check on the incoming item
  always_comb begin
    pc_w     = CW'(point_count);
    cnt_live = pc_w;
    if (pc_w < CW'(2)) cnt_live = CW'(2);
    if (pc_w > CW'(MAX_POINTS)) cnt_live = CW'(MAX_POINTS);
    idx_live   = CW'(in_point_index);
    sts.in_bad = idx_live >= cnt_live;
    wr_en      = cmd.latch && (in_kind == tpi_pkg::KIND_WRITE) &&
                 (idx_live < CW'(MAX_POINTS));
  end

  // Item registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cnt   <= cnt_live;
      idx   <= idx_live;
      w     <= (in_weight > tpi_pkg::W_FULL) ? tpi_pkg::W_FULL : in_weight;
      bad_q <= sts.in_bad;
    end
  end

  // Point store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx_live[AW-1:0]] <= '{x: in_new_x, y: in_new_y, z: in_new_z, ang: in_new_angle};
    end
    if (cmd.rd_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
  end

  // Segment start and its successor, wrapping at the count
  always_comb begin
    idx_e   = IW'(idx);
    cnt_e   = IW'(cnt);
    back    = (idx_e >= IW'(2)) ? (idx_e - IW'(2)) : (cnt_e - IW'(2) + idx_e);
    fwd_raw = idx_e + IW'(2);
    fwd     = (fwd_raw >= cnt_e) ? (fwd_raw - cnt_e) : fwd_raw;
    case (cmd.addr_sel)
      tpi_pkg::ADDR_BACK: base = back;
      tpi_pkg::ADDR_FWD:  base = fwd;
      default:            base = idx_e;
    endcase
    succ_raw = base + IW'(1);
    succ     = (succ_raw == cnt_e) ? '0 : succ_raw;
    addr_a   = base[AW-1:0];
    addr_b   = succ[AW-1:0];
  end

  // Operand selection for the multiply-add
  assign acc_h = acc[tpi_pkg::ANG_W+9:10];

  always_comb begin
    case (cmd.mac_src)
      tpi_pkg::MAC_H01: begin ang_a = h[0]; ang_b = h[1]; end
      tpi_pkg::MAC_H02: begin ang_a = h[0]; ang_b = h[2]; end
      tpi_pkg::MAC_H3A: begin ang_a = h[3]; ang_b = acc_h; end
      default:          begin ang_a = rd_a.ang; ang_b = rd_b.ang; end
    endcase
    pair = wrap_pair(ang_a, ang_b);
    case (cmd.mac_src)
      tpi_pkg::MAC_X: begin
        op_a = {rd_a.x[tpi_pkg::COORD_W-1], rd_a.x};
        op_b = {rd_b.x[tpi_pkg::COORD_W-1], rd_b.x};
      end
      tpi_pkg::MAC_Y: begin
        op_a = {rd_a.y[tpi_pkg::COORD_W-1], rd_a.y};
        op_b = {rd_b.y[tpi_pkg::COORD_W-1], rd_b.y};
      end
      tpi_pkg::MAC_Z: begin
        op_a = {rd_a.z[tpi_pkg::COORD_W-1], rd_a.z};
        op_b = {rd_b.z[tpi_pkg::COORD_W-1], rd_b.z};
      end
      default: begin
        op_a = {9'd0, pair[2*tpi_pkg::ANG_W+1:tpi_pkg::ANG_W+1]};
        op_b = {9'd0, pair[tpi_pkg::ANG_W:0]};
      end
    endcase
    wv     = cmd.half_w ? tpi_pkg::W_HALF : w;
    inv    = tpi_pkg::W_FULL - wv;
    prod_a = tpi_pkg::ACC_W'(op_a) * tpi_pkg::ACC_W'($signed({1'b0, inv}));
    prod_b = tpi_pkg::ACC_W'(op_b) * tpi_pkg::ACC_W'($signed({1'b0, wv}));
  end

  // Accumulator and saved partial results
  always_ff @(posedge clk) begin
    if (!cmd.hold) acc <= prod_a + prod_b;
    if (cmd.save_x) res_x <= acc_r10[tpi_pkg::COORD_W+9:10];
    if (cmd.save_y) res_y <= acc_r11[tpi_pkg::YOUT_W+10:11];
    if (cmd.hsave)  h[cmd.hsel] <= acc_h;
  end

  // Round toward zero on the arithmetic shifts
  always_comb begin
    acc_r10 = acc + (acc[tpi_pkg::ACC_W-1] ? tpi_pkg::ACC_W'(1023) : '0);
    acc_r11 = acc + (acc[tpi_pkg::ACC_W-1] ? tpi_pkg::ACC_W'(2047) : '0);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pos_x     <= '0;
      pos_y     <= '0;
      pos_z     <= '0;
      angle_out <= '0;
      bad_index <= bad_q;
      case (cmd.res_sel)
        tpi_pkg::RES_NONE: bad_index <= 1'b0;
        tpi_pkg::RES_POS: begin
          pos_x <= res_x;
          pos_y <= res_y;
          pos_z <= acc_r10[tpi_pkg::COORD_W+9:10];
        end
        tpi_pkg::RES_ANG: angle_out <= {1'b0, acc_h};
        tpi_pkg::RES_REV: angle_out <= 13'sh800 - $signed({1'b0, acc_h});
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/track_path_interpolator_unit.sv
// Items are handled one at a time: a new item is accepted only in the idle state, after
// the previous result has been loaded. A write, a bad index or an unknown kind goes straight
// to the result; other queries are paced by the single shared multiply-add unit and the
// two read ports of the point store. A held result keeps the controller in its last state,
// so the next item waits. Reset (rst, synchronous): controller idle, output empty,
// point_count 2; point store keeps its contents, valid only where written.
module track_path_interpolator_unit #(
  parameter int MAX_POINTS = 256
) (
  input logic       clk,
  input logic       rst,
  tpi_req_if.sink   req,
  tpi_res_if.source res,
  tpi_cfg_if.sink   cfg
);

  tpi_pkg::cmd_t cmd;
  tpi_pkg::sts_t sts;

  assign cfg.ready = 1'b1;

  tpi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_kind   (req.kind),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tpi_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg.valid),
    .cfg_data       (cfg.point_count),
    .in_kind        (req.kind),
    .in_point_index (req.point_index),
    .in_weight      (req.weight),
    .in_new_x       (req.new_x),
    .in_new_y       (req.new_y),
    .in_new_z       (req.new_z),
    .in_new_angle   (req.new_angle),
    .cmd            (cmd),
    .sts            (sts),
    .pos_x          (res.pos_x),
    .pos_y          (res.pos_y),
    .pos_z          (res.pos_z),
    .angle_out      (res.angle_out),
    .bad_index      (res.bad_index)
  );

endmodule

// File: tb/tb_top.sv
module tb_top;

  localparam int NPOINTS = 256;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    logic [tpi_pkg::KIND_W-1:0]         kind;
    logic [tpi_pkg::IDX_W-1:0]          idx;
    logic [tpi_pkg::W_W-1:0]            w;
    logic signed [tpi_pkg::COORD_W-1:0] x;
    logic signed [tpi_pkg::COORD_W-1:0] y;
    logic signed [tpi_pkg::COORD_W-1:0] z;
    logic [tpi_pkg::ANG_W-1:0]          ang;
  } path_item_t;

  typedef struct {
    logic signed [tpi_pkg::COORD_W-1:0] x;
    logic signed [tpi_pkg::YOUT_W-1:0]  y;
    logic signed [tpi_pkg::COORD_W-1:0] z;
    logic signed [tpi_pkg::AOUT_W-1:0]  ang;
    logic                               bad;
  } path_result_t;

  // Predicts the interpolator and keeps the results still owed by the block
  class path_scoreboard;
    logic signed [tpi_pkg::COORD_W-1:0] xs[NPOINTS];
    logic signed [tpi_pkg::COORD_W-1:0] ys[NPOINTS];
    logic signed [tpi_pkg::COORD_W-1:0] zs[NPOINTS];
    logic [tpi_pkg::ANG_W-1:0]          hs[NPOINTS];
    logic [tpi_pkg::CNT_W-1:0]          count_reg = tpi_pkg::CNT_RESET;
    path_result_t                       owed_q[$];
    int                                 mismatches = 0;
    int                                 checked = 0;

    function int eff_count();
      if (count_reg < 2) return 2;
      if (count_reg > NPOINTS) return NPOINTS;
      return count_reg;
    endfunction

    // shorter-way blend of two headings
    function logic [tpi_pkg::ANG_W-1:0] blend(logic [tpi_pkg::ANG_W-1:0] a,
                                              logic [tpi_pkg::ANG_W-1:0] b,
                                              int unsigned w);
      int unsigned lo, hi;
      lo = a;
      hi = b;
      if (hi < lo) begin
        if (lo - hi >= 32'h801) hi += 32'h1000;
      end else if (hi - lo >= 32'h801) begin
        lo += 32'h1000;
      end
      return tpi_pkg::ANG_W'((lo * (32'h400 - w) + hi * w) >> 10);
    endfunction

    function logic [tpi_pkg::ANG_W-1:0] seg_heading(int idx, int unsigned w, int cnt);
      return blend(hs[idx], hs[(idx + 1) % cnt], w);
    endfunction

    function longint lerp(logic signed [tpi_pkg::COORD_W-1:0] a,
                          logic signed [tpi_pkg::COORD_W-1:0] b,
                          int unsigned w, longint dv);
      longint s;
      s = longint'(a) * longint'(1024 - w) + longint'(b) * longint'(w);
      return s / dv;
    endfunction

    function void note_item(path_item_t it);
      path_result_t r;
      int cnt, i, nxt, back, fwd;
      int unsigned w;
      logic [tpi_pkg::ANG_W-1:0] mid, lft, rgt;
      r = '{x: '0, y: '0, z: '0, ang: '0, bad: 1'b0};
      cnt = eff_count();
      i = it.idx;
      w = (it.w > tpi_pkg::W_FULL) ? tpi_pkg::W_FULL : it.w;
      if (it.kind <= tpi_pkg::KIND_SMOOTH) begin
        r.bad = (i >= cnt);
        if (it.kind == tpi_pkg::KIND_WRITE) begin
          xs[i] = it.x;
          ys[i] = it.y;
          zs[i] = it.z;
          hs[i] = it.ang;
        end else if (!r.bad) begin
          nxt = (i + 1) % cnt;
          case (it.kind)
            tpi_pkg::KIND_POS: begin
              r.x = tpi_pkg::COORD_W'(lerp(xs[i], xs[nxt], w, 1024));
              r.y = tpi_pkg::YOUT_W'(lerp(ys[i], ys[nxt], w, 2048));
              r.z = tpi_pkg::COORD_W'(lerp(zs[i], zs[nxt], w, 1024));
            end
            tpi_pkg::KIND_ANG: r.ang = tpi_pkg::AOUT_W'(seg_heading(i, w, cnt));
            tpi_pkg::KIND_REV:
              r.ang = tpi_pkg::AOUT_W'(2048 - int'(seg_heading(i, w, cnt)));
            default: begin
              back = (i >= 2) ? i - 2 : cnt - 2 + i;
              fwd = (i + 2) % cnt;
              mid = seg_heading(i, w, cnt);
              lft = blend(mid, seg_heading(back, w, cnt), tpi_pkg::W_HALF);
              rgt = blend(mid, seg_heading(fwd, w, cnt), tpi_pkg::W_HALF);
              r.ang = tpi_pkg::AOUT_W'(blend(lft, rgt, tpi_pkg::W_HALF));
            end
          endcase
        end
      end
      owed_q.push_back(r);
    endfunction

    function void check_result(path_result_t got);
      path_result_t e;
      checked++;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result: x=%0d y=%0d z=%0d ang=%0d bad=%0b",
                   got.x, got.y, got.z, got.ang, got.bad);
        return;
      end
      e = owed_q.pop_front();
      if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.ang !== e.ang ||
          got.bad !== e.bad) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display({"result %0d mismatch: exp x=%0d y=%0d z=%0d ang=%0d bad=%0b,",
                    " got x=%0d y=%0d z=%0d ang=%0d bad=%0b"},
                   checked, e.x, e.y, e.z, e.ang, e.bad,
                   got.x, got.y, got.z, got.ang, got.bad);
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  tpi_req_if req_if();
  tpi_res_if res_if();
  tpi_cfg_if cfg_if();

  path_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int items_sent;
  int cur_eff;

  track_path_interpolator_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if.sink),
    .res (res_if.source),
    .cfg (cfg_if.sink)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #(12 * 1500000);
    $display("timeout");
    $display("** track_path_interpolator_unit: FAILED **");
    $finish;
  end

  // receiver stalls
  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // monitors: accepted items, config writes, results
  always @(posedge clk) begin
    path_item_t it;
    path_result_t r;
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) sb.count_reg = cfg_if.point_count;
      if (req_if.valid && req_if.ready) begin
        it.kind = req_if.kind;
        it.idx = req_if.point_index;
        it.w = req_if.weight;
        it.x = req_if.new_x;
        it.y = req_if.new_y;
        it.z = req_if.new_z;
        it.ang = req_if.new_angle;
        sb.note_item(it);
      end
      if (res_if.valid && res_if.ready) begin
        r.x = res_if.pos_x;
        r.y = res_if.pos_y;
        r.z = res_if.pos_z;
        r.ang = res_if.angle_out;
        r.bad = res_if.bad_index;
        sb.check_result(r);
      end
    end
  end

  task automatic send_item(path_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.kind <= it.kind;
    req_if.point_index <= it.idx;
    req_if.weight <= it.w;
    req_if.new_x <= it.x;
    req_if.new_y <= it.y;
    req_if.new_z <= it.z;
    req_if.new_angle <= it.ang;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_count(int v);
    cfg_if.valid <= 1'b1;
    cfg_if.point_count <= tpi_pkg::CNT_W'(v);
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    cur_eff = (v < 2) ? 2 : ((v > NPOINTS) ? NPOINTS : v);
  endtask

  function automatic logic signed [tpi_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(7))
      0: return {1'b1, {(tpi_pkg::COORD_W-1){1'b0}}};
      1: return {1'b0, {(tpi_pkg::COORD_W-1){1'b1}}};
      2: return '1;
      default: return tpi_pkg::COORD_W'($urandom);
    endcase
  endfunction

  function automatic logic [tpi_pkg::ANG_W-1:0] rand_heading();
    case ($urandom_range(5))
      0: return tpi_pkg::ANG_W'($urandom_range(15));
      1: return tpi_pkg::ANG_W'(4095 - $urandom_range(15));
      2: return tpi_pkg::ANG_W'(2040 + $urandom_range(16));
      default: return tpi_pkg::ANG_W'($urandom);
    endcase
  endfunction

  function automatic path_item_t make_item(logic [tpi_pkg::KIND_W-1:0] k, int i, int w);
    path_item_t it;
    it.kind = k;
    it.idx = tpi_pkg::IDX_W'(i);
    it.w = tpi_pkg::W_W'(w);
    it.x = rand_coord();
    it.y = rand_coord();
    it.z = rand_coord();
    it.ang = rand_heading();
    return it;
  endfunction

  function automatic path_item_t rand_item();
    int r, i, w;
    logic [tpi_pkg::KIND_W-1:0] k;
    r = $urandom_range(99);
    if (r < 15) k = tpi_pkg::KIND_WRITE;
    else if (r < 18) k = tpi_pkg::KIND_W'($urandom_range(5, 7));
    else k = tpi_pkg::KIND_W'($urandom_range(1, 4));
    i = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(cur_eff - 1);
    r = $urandom_range(19);
    if (r < 2) w = 0;
    else if (r < 4) w = 1024;
    else if (r == 4) w = $urandom_range(1025, 2047);
    else w = $urandom_range(1024);
    return make_item(k, i, w);
  endfunction

  initial begin
    int counts[8];
    path_item_t it;
    sb = new();
    items_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cur_eff = 2;
    req_if.valid <= 1'b0;
    req_if.kind <= tpi_pkg::KIND_WRITE;
    req_if.point_index <= '0;
    req_if.weight <= '0;
    req_if.new_x <= '0;
    req_if.new_y <= '0;
    req_if.new_z <= '0;
    req_if.new_angle <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.point_count <= tpi_pkg::CNT_RESET;
    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every point so no query touches an unwritten entry
    write_count(NPOINTS);
    for (int i = 0; i < NPOINTS; i++) send_item(make_item(tpi_pkg::KIND_WRITE, i, 0));

    // directed: extreme points, wrap cases, every kind, weight edges
    it = make_item(tpi_pkg::KIND_WRITE, 255, 0);
    it.x = {1'b1, {(tpi_pkg::COORD_W-1){1'b0}}};
    it.y = {1'b0, {(tpi_pkg::COORD_W-1){1'b1}}};
    it.z = '1;
    it.ang = 12'hFFF;
    send_item(it);
    it = make_item(tpi_pkg::KIND_WRITE, 0, 0);
    it.x = {1'b0, {(tpi_pkg::COORD_W-1){1'b1}}};
    it.y = {1'b1, {(tpi_pkg::COORD_W-1){1'b0}}};
    it.z = '0;
    it.ang = 12'h000;
    send_item(it);
    it = make_item(tpi_pkg::KIND_WRITE, 1, 0);
    it.ang = 12'h800;
    send_item(it);
    it = make_item(tpi_pkg::KIND_WRITE, 2, 0);
    it.ang = 12'h801;
    send_item(it);
    send_item(make_item(tpi_pkg::KIND_POS, 255, 0));
    send_item(make_item(tpi_pkg::KIND_POS, 255, 1024));
    send_item(make_item(tpi_pkg::KIND_POS, 255, 2047));
    send_item(make_item(tpi_pkg::KIND_POS, 0, 512));
    send_item(make_item(tpi_pkg::KIND_ANG, 255, 512));
    send_item(make_item(tpi_pkg::KIND_ANG, 0, 1024));
    send_item(make_item(tpi_pkg::KIND_ANG, 1, 300));
    send_item(make_item(tpi_pkg::KIND_REV, 0, 0));
    send_item(make_item(tpi_pkg::KIND_REV, 255, 700));
    send_item(make_item(tpi_pkg::KIND_SMOOTH, 0, 200));
    send_item(make_item(tpi_pkg::KIND_SMOOTH, 1, 1024));
    send_item(make_item(tpi_pkg::KIND_SMOOTH, 255, 900));
    send_item(make_item(3'd5, 3, 100));
    send_item(make_item(3'd6, 4, 1500));
    send_item(make_item(3'd7, 255, 2047));

    // random phases over point counts, including out-of-range register values
    counts = '{2, 256, 3, 0, 511, 1, $urandom_range(4, 255), 17};
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      write_count(counts[p]);
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 63; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 63; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      for (int n = 0; n < 128; n++) send_item(rand_item());
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("covered %0d items (%0d results checked) over 8 point-count settings",
             items_sent, sb.checked);
    $display("with idle and stall phases on both sides, %0d mismatches", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("** track_path_interpolator_unit: PASSED **");
    else
      $display("** track_path_interpolator_unit: FAILED **");
    $finish;
  end

endmodule
